// ===== rtl/core/rx_ring_buffer_line_extract_assert.svh =====
// Assertion macros shared by the receive ring buffer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RX_RING_BUFFER_LINE_EXTRACT_ASSERT_SVH
`define RX_RING_BUFFER_LINE_EXTRACT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define RRLE_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RRLE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rrle_pkg.sv =====
// Shared types and constants of the receive ring buffer with line framing.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package rrle_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned OUT_TDATA_W = 16;

  // Command queue between front and back (power of two, pointers wrap naturally)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
  } req_t;

  // One result transfer
  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrle_front.sv =====
// Front end: accepts input transfers, classifies the command and queues it.
// Depends on rrle_pkg; feeds rrle_back through a short command queue.
`default_nettype none

`include "rx_ring_buffer_line_extract_assert.svh"

module rrle_front
  import rrle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [CMD_W-1:0]  s_cmd_i,
  input  logic [BYTE_W-1:0] s_data_i,
  output logic              req_valid_o,
  input  logic              req_ready_i,
  output req_t              req_o
);

  req_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  req_t              entry;

  // Classify the incoming command
  always_comb begin
    entry.cmd  = cmd_e'(s_cmd_i);
    entry.data = s_data_i;
  end

  assign s_ready_o   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = queue_q[rd_ptr_q];

  assign push = s_valid_i & s_ready_o;
  assign pop  = req_valid_o & req_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

  `RRLE_ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH),
    "command queue count exceeds its depth")

endmodule

`default_nettype wire

// ===== rtl/core/rrle_back.sv =====
// Back end: ring store, pointers, line scan sequencer and output register.
// Depends on rrle_pkg; takes classified commands from rrle_front.
`default_nettype none

`include "rx_ring_buffer_line_extract_assert.svh"

module rrle_back
  import rrle_pkg::*;
#(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned LINE_MAX = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = $clog2(LINE_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_OUT,
    ST_SCAN,
    ST_EM_OUT,
    ST_NULL_OUT,
    ST_MISS_OUT
  } state_e;

  // Step a store pointer by one with wrap
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_q;

  state_e            st_q, st_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [PW-1:0]     sp_q, sp_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [LW-1:0]     lim_q, lim_d;
  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;

  logic              out_free, emit, take, full;
  logic              wr_en, rd_en;
  logic [PW-1:0]     rd_addr;
  logic [LW-1:0]     lim_now;
  logic              em_last;

  assign out_free    = !out_vld_q || out_ready_i;
  assign req_ready_o = (st_q == ST_IDLE) && out_free;
  assign take        = req_valid_i && req_ready_o;
  assign full        = (cnt_q == CW'(DEPTH));
  assign em_last     = ((pos_q + LW'(1)) == len_q);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  // Scan window: the oldest bytes up to the line limit
  always_comb begin
    if (32'(cnt_q) > 32'(LINE_MAX)) begin
      lim_now = LW'(LINE_MAX);
    end else begin
      lim_now = LW'(cnt_q);
    end
  end

  // Sequence commands against the store
  always_comb begin
    st_d    = st_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    sp_d    = sp_q;
    cnt_d   = cnt_q;
    lim_d   = lim_q;
    idx_d   = idx_q;
    len_d   = len_q;
    pos_d   = pos_q;
    emit    = 1'b0;
    res_d   = '{status: STAT_OK, out_byte: '0, line_length: '0, last: 1'b1};
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = rp_q;

    case (st_q)
      ST_IDLE: begin
        if (take) begin
          case (req_i.cmd)
            CMD_PUSH: begin
              emit = 1'b1;
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                wr_en = 1'b1;
                wp_d  = wrap_inc(wp_q);
                cnt_d = cnt_q + CW'(1);
              end
            end
            CMD_POP: begin
              if (cnt_q == '0) begin
                emit         = 1'b1;
                res_d.status = STAT_NONE;
              end else begin
                rd_en = 1'b1;
                st_d  = ST_POP_OUT;
              end
            end
            CMD_LINE: begin
              if (lim_now == '0) begin
                emit         = 1'b1;
                res_d.status = STAT_NONE;
              end else begin
                rd_en = 1'b1;
                sp_d  = rp_q;
                idx_d = '0;
                lim_d = lim_now;
                st_d  = ST_SCAN;
              end
            end
            CMD_FLUSH: begin
              emit  = 1'b1;
              wp_d  = '0;
              rp_d  = '0;
              cnt_d = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_POP_OUT: begin
        if (out_free) begin
          emit           = 1'b1;
          res_d.out_byte = rd_q;
          rp_d           = wrap_inc(rp_q);
          cnt_d          = cnt_q - CW'(1);
          st_d           = ST_IDLE;
        end
      end

      // Check one byte per cycle while fetching the next
      ST_SCAN: begin
        if (rd_q == NEWLINE_CODE) begin
          len_d = idx_q;
          if (idx_q == '0) begin
            st_d = ST_NULL_OUT;
          end else begin
            rd_en = 1'b1;
            pos_d = '0;
            st_d  = ST_EM_OUT;
          end
        end else if ((idx_q + LW'(1)) == lim_q) begin
          st_d = ST_MISS_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = wrap_inc(sp_q);
          sp_d    = wrap_inc(sp_q);
          idx_d   = idx_q + LW'(1);
        end
      end

      // Emit message bytes, consume the newline after the last one
      ST_EM_OUT: begin
        if (out_free) begin
          emit              = 1'b1;
          res_d.out_byte    = rd_q;
          res_d.line_length = LEN_W'(len_q);
          res_d.last        = em_last;
          if (em_last) begin
            rp_d  = wrap_inc(wrap_inc(rp_q));
            cnt_d = cnt_q - CW'(2);
            st_d  = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = wrap_inc(rp_q);
            rp_d    = wrap_inc(rp_q);
            cnt_d   = cnt_q - CW'(1);
            pos_d   = pos_q + LW'(1);
          end
        end
      end

      ST_NULL_OUT: begin
        if (out_free) begin
          emit  = 1'b1;
          rp_d  = wrap_inc(rp_q);
          cnt_d = cnt_q - CW'(1);
          st_d  = ST_IDLE;
        end
      end

      ST_MISS_OUT: begin
        if (out_free) begin
          emit         = 1'b1;
          res_d.status = STAT_NONE;
          st_d         = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase

    out_vld_d = emit || (out_vld_q && !out_ready_i);
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      sp_q      <= '0;
      cnt_q     <= '0;
      lim_q     <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      sp_q      <= sp_d;
      cnt_q     <= cnt_d;
      lim_q     <= lim_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= req_i.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  `RRLE_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH),
    "fill count exceeds store depth")
  `RRLE_ASSERT_IMPLY(a_empty_ptr, clk_i, rst_ni, cnt_q == '0, rp_q == wp_q,
    "empty store with unequal pointers")
  `RRLE_ASSERT_IMPLY(a_emit_pos, clk_i, rst_ni, st_q == ST_EM_OUT,
    (len_q != '0) && (pos_q < len_q), "message position outside line length")
  `RRLE_ASSERT_IMPLY(a_scan_idx, clk_i, rst_ni, st_q == ST_SCAN,
    (idx_q < lim_q) && (32'(lim_q) <= 32'(cnt_q)), "scan index outside window")

endmodule

`default_nettype wire

// ===== rtl/core/rx_ring_buffer_line_extract.sv =====
// Receive ring buffer with line framing: rrle_front queues commands, rrle_back runs them.
// Push: passes the front queue and the output register; one push per cycle sustained while
// the sink is ready. Pop: passes the front queue, the registered store read and the output
// register; no new command is taken until the popped byte is loaded. Take-line: scan the
// window to the newline, then emit message bytes while the sink is ready (single store read port).
// Reset clears pointers, counts, queue and output valid; the store is not cleared.
`default_nettype none

module rx_ring_buffer_line_extract
  import rrle_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 256,
  parameter int unsigned LINE_MAX     = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic [CMD_W-1:0]       s_axis_tuser,  // [1:0] cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [13:8] line_length
  output logic [STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  output logic                   m_axis_tlast   // last
);

  req_t req;
  logic req_valid, req_ready;
  res_t res;

  rrle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_cmd_i     (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  rrle_back #(
    .DEPTH    (BUFFER_DEPTH),
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result transfer
  assign m_axis_tdata = {{(OUT_TDATA_W - LEN_W - BYTE_W){1'b0}}, res.line_length, res.out_byte};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== dv/line_buffer_checker.sv =====
// Scoreboard for the receive ring buffer with line framing: mirrors the byte store,
// predicts every result transfer and compares it with what the block sends.
// Depends on rrle_pkg; instantiated by the testbench top beside the block.
`default_nettype none

module line_buffer_checker
  import rrle_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 256,
  parameter int unsigned LINE_MAX     = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic [CMD_W-1:0]       s_axis_tuser,  // [1:0] cmd
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [13:8] line_length
  input  logic [STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  input  logic                   m_axis_tlast,  // last
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int unsigned PRINT_CAP = 100;

  // Mirror of the block state
  logic [BYTE_W-1:0] mirror_bytes [BUFFER_DEPTH];
  int unsigned       mirror_wr_ptr;
  int unsigned       mirror_rd_ptr;
  int unsigned       mirror_fill;

  res_t expected_results [$];
  int   mismatch_total;

  // Print one line per bad transfer, for the first PRINT_CAP of them, and count every one
  task automatic report_mismatch(input string msg);
    if (mismatch_total < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_total++;
  endtask

  task automatic queue_result(input status_e st, input logic [BYTE_W-1:0] b,
                              input logic [LEN_W-1:0] len, input logic lst);
    res_t r;
    r.status      = st;
    r.out_byte    = b;
    r.line_length = len;
    r.last        = lst;
    expected_results.push_back(r);
  endtask

  // Work out the result transfers caused by one command
  task automatic predict_command(input cmd_e cmd, input logic [BYTE_W-1:0] data);
    int unsigned span;
    int unsigned pos;
    case (cmd)
      CMD_PUSH: begin
        if (mirror_fill >= BUFFER_DEPTH) begin
          queue_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          mirror_bytes[mirror_wr_ptr] = data;
          mirror_wr_ptr = (mirror_wr_ptr + 1) % BUFFER_DEPTH;
          mirror_fill++;
          queue_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      CMD_POP: begin
        if (mirror_fill == 0) begin
          queue_result(STAT_NONE, '0, '0, 1'b1);
        end else begin
          queue_result(STAT_OK, mirror_bytes[mirror_rd_ptr], '0, 1'b1);
          mirror_rd_ptr = (mirror_rd_ptr + 1) % BUFFER_DEPTH;
          mirror_fill--;
        end
      end
      CMD_LINE: begin
        span = (mirror_fill > LINE_MAX) ? LINE_MAX : mirror_fill;
        pos  = 0;
        while (pos < span &&
               mirror_bytes[(mirror_rd_ptr + pos) % BUFFER_DEPTH] != NEWLINE_CODE) begin
          pos++;
        end
        if (pos >= span) begin
          // No complete line: leave the store untouched
          queue_result(STAT_NONE, '0, '0, 1'b1);
        end else begin
          if (pos == 0) begin
            queue_result(STAT_OK, '0, '0, 1'b1);
          end else begin
            for (int unsigned j = 0; j < pos; j++) begin
              queue_result(STAT_OK, mirror_bytes[(mirror_rd_ptr + j) % BUFFER_DEPTH],
                           LEN_W'(pos), (j + 1 == pos));
            end
          end
          // Consume the message together with its newline
          mirror_rd_ptr = (mirror_rd_ptr + pos + 1) % BUFFER_DEPTH;
          mirror_fill   = mirror_fill - (pos + 1);
        end
      end
      default: begin
        mirror_wr_ptr = 0;
        mirror_rd_ptr = 0;
        mirror_fill   = 0;
        queue_result(STAT_OK, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Compare one result transfer against the oldest expectation
  task automatic check_result();
    res_t  want;
    string got;
    got = $sformatf("status=%0d byte=%02h len=%0d last=%0b pad=%0b",
                    m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
                    m_axis_tlast, m_axis_tdata[15:14]);
    if (expected_results.size() == 0) begin
      report_mismatch({"unexpected transfer: ", got});
    end else begin
      want = expected_results.pop_front();
      if (m_axis_tuser !== want.status || m_axis_tdata[7:0] !== want.out_byte ||
          m_axis_tdata[13:8] !== want.line_length || m_axis_tlast !== want.last ||
          m_axis_tdata[15:14] !== 2'b00) begin
        report_mismatch($sformatf("got %s, want status=%0d byte=%02h len=%0d last=%0b",
                                  got, want.status, want.out_byte, want.line_length,
                                  want.last));
      end
    end
  endtask

  // Retire outputs before new predictions so a same-edge input cannot match them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      mirror_wr_ptr  = 0;
      mirror_rd_ptr  = 0;
      mirror_fill    = 0;
      mismatch_total = 0;
      pending_o     <= 0;
      fail_count_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the ring buffer testbench: clock, reset, command stimulus and sink backpressure.
// Depends on rrle_pkg, rx_ring_buffer_line_extract and line_buffer_checker.
`default_nettype none

module testbench;
  import rrle_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned LINE_SPAN   = 64;
  localparam int unsigned PHASE_TAKES = 6;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = CMD_PUSH;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  rx_ring_buffer_line_extract #(
    .BUFFER_DEPTH(DEPTH),
    .LINE_MAX    (LINE_SPAN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  line_buffer_checker #(
    .BUFFER_DEPTH(DEPTH),
    .LINE_MAX    (LINE_SPAN)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stall the sink at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hang guard
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one command and hold it until the transfer completes
  task automatic send_item(input cmd_e cmd, input logic [BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == NEWLINE_CODE);
    return b;
  endfunction

  // Fill an empty store: a run as long as the scan window without a newline,
  // then its newline, then random lines up to capacity ending in a newline
  task automatic fill_store();
    int unsigned stored;
    repeat (LINE_SPAN) send_item(CMD_PUSH, text_byte());
    send_item(CMD_PUSH, NEWLINE_CODE);
    stored = LINE_SPAN + 1;
    while (stored < DEPTH) begin
      if (stored == DEPTH - 1 || $urandom_range(0, 7) == 0) begin
        send_item(CMD_PUSH, NEWLINE_CODE);
      end else begin
        send_item(CMD_PUSH, text_byte());
      end
      stored++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty buffer, extreme bytes, empty line, missing newline, flush
    send_item(CMD_POP, 8'hFF);
    send_item(CMD_LINE, 8'h00);
    send_item(CMD_PUSH, 8'h00);
    send_item(CMD_PUSH, 8'hFF);
    send_item(CMD_PUSH, NEWLINE_CODE);
    send_item(CMD_LINE, 8'h0A);
    send_item(CMD_PUSH, NEWLINE_CODE);
    send_item(CMD_LINE, 8'h00);
    send_item(CMD_PUSH, 8'h55);
    send_item(CMD_PUSH, 8'hAA);
    send_item(CMD_LINE, 8'h00);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_PUSH, 8'h0B);
    send_item(CMD_PUSH, 8'h09);
    send_item(CMD_FLUSH, 8'hFF);
    send_item(CMD_POP, 8'h00);
    send_item(CMD_LINE, 8'h00);
    send_item(CMD_PUSH, 8'h80);
    send_item(CMD_PUSH, NEWLINE_CODE);
    send_item(CMD_LINE, 8'h00);
    wait_drained();

    // Fill to capacity with the write pointer wrapping, overflow once
    fill_store();
    send_item(CMD_PUSH, text_byte());
    // Newline sits just past the scan window: no line, drop one byte, then it fits
    send_item(CMD_LINE, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_LINE, '0);
    wait_drained();

    // Take the stored lines, with the odd pop, under different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (PHASE_TAKES) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)));
        end else begin
          send_item(CMD_LINE, BYTE_W'($urandom_range(0, 255)));
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
